### rtl/core/swir_pkg.sv
// Shared types, codes and CRC-32 helpers for the stop-and-wait image receiver.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package swir_pkg;

	// Field widths fixed by the frame format
	localparam int unsigned DATA_W    = 56;
	localparam int unsigned SEQ_W     = 8;
	localparam int unsigned CMD_W     = 3;
	localparam int unsigned CNT_W     = 3;
	localparam int unsigned LEN_W     = 32;
	localparam int unsigned CRC_W     = 32;
	localparam int unsigned IN_DATA_W = SEQ_W + DATA_W;
	localparam int unsigned OUT_DATA_W = 72;
	localparam int unsigned OUT_USER_W = 2;

	localparam int unsigned PAYLOAD_BYTES_DEF = 7;

	// zlib CRC-32, reflected polynomial
	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

	// Bit positions of the result fields on the master-side tdata
	localparam int unsigned O_CODE_LSB   = 0;
	localparam int unsigned O_ARG_LSB    = 3;
	localparam int unsigned O_WDATA_LSB  = 11;
	localparam int unsigned O_WCOUNT_LSB = 67;
	localparam int unsigned O_ACTIVE_BIT = 70;
	localparam int unsigned O_REBOOT_BIT = 71;

	// Frame kinds; any other code is a frame that is ignored
	typedef enum logic [CMD_W-1:0] {
		CMD_BEGIN = 3'd0,
		CMD_END   = 3'd1,
		CMD_ABORT = 3'd2,
		CMD_DATA  = 3'd3
	} cmd_t;

	// Status frame codes
	typedef enum logic [2:0] {
		ST_READY = 3'd0,
		ST_ACK   = 3'd1,
		ST_NAK   = 3'd2,
		ST_ERR   = 3'd3,
		ST_DONE  = 3'd4
	} status_t;

	// Error arguments
	localparam logic [SEQ_W-1:0] ERR_STATE = 8'd0;
	localparam logic [SEQ_W-1:0] ERR_SIZE  = 8'd1;
	localparam logic [SEQ_W-1:0] ERR_CRC   = 8'd2;

	// One result item
	typedef struct packed {
		logic                status_valid;
		status_t             status_code;
		logic [SEQ_W-1:0]    status_arg;
		logic                write_valid;
		logic [DATA_W-1:0]   write_data;
		logic [CNT_W-1:0]    write_count;
		logic                active_now;
		logic                reboot_request;
	} result_t;

	typedef logic [CRC_W-1:0][CRC_W-1:0]  crc_smat_t;
	typedef logic [DATA_W-1:0][CRC_W-1:0] crc_dmat_t;

	// Bitwise CRC over n bytes on the inverted register; elaboration use only
	function automatic logic [CRC_W-1:0] crc_raw(logic [CRC_W-1:0] x_in,
			logic [DATA_W-1:0] d, int unsigned n);
		logic [CRC_W-1:0] x;
		x = x_in;
		for (int unsigned i = 0; i < n; i++) begin
			x = x ^ {24'd0, d[8*i +: 8]};
			for (int k = 0; k < 8; k++) begin
				x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
			end
		end
		return x;
	endfunction

	// Contribution of each register bit after n bytes
	function automatic crc_smat_t crc_state_mat(int unsigned n);
		crc_smat_t m;
		for (int i = 0; i < CRC_W; i++) begin
			m[i] = crc_raw(CRC_W'(1) << i, '0, n);
		end
		return m;
	endfunction

	// Contribution of each data bit after n bytes; bits past n bytes add nothing
	function automatic crc_dmat_t crc_data_mat(int unsigned n);
		crc_dmat_t m;
		for (int j = 0; j < DATA_W; j++) begin
			m[j] = (j < 8 * n) ? crc_raw('0, DATA_W'(1) << j, n) : '0;
		end
		return m;
	endfunction

	// XOR the selected columns: a flat XOR tree per output bit
	function automatic logic [CRC_W-1:0] crc_apply(crc_smat_t ms, crc_dmat_t md,
			logic [CRC_W-1:0] x, logic [DATA_W-1:0] d);
		logic [CRC_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < CRC_W; i++) begin
			if (x[i]) acc = acc ^ ms[i];
		end
		for (int j = 0; j < DATA_W; j++) begin
			if (d[j]) acc = acc ^ md[j];
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

### rtl/core/stop_and_wait_image_receiver_core.sv
// Top level of the stop-and-wait image receiver: input register, frame
// control and output register. Depends on swir_pkg and swir_ctrl.
//
//  Channel  | Direction | tdata (low bit up)                     | tuser
//  ---------+-----------+----------------------------------------+---------------------------
//  s_*      | in        | seq[7:0], payload[55:0]                | cmd[2:0]
//  m_*      | out       | code, arg, wdata, wcount, active, boot | status_valid, write_valid
//
// One frame per cycle sustained while m_tready stays high; each frame passes
// through the input register and then the result register on its way out.
// The full frame work (decode, 32-bit room compare, 56-bit CRC XOR network)
// sits between the input register and the result register.
// A stalled output holds its result; while it waits the input register takes
// one more frame if it is empty and then holds s_tready low.
// Reset clears the transfer state to idle and empties both registers.
`default_nettype none

module stop_and_wait_image_receiver_core #(
	parameter int unsigned PAYLOAD_BYTES = swir_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [swir_pkg::IN_DATA_W-1:0]    s_tdata,  // seq, payload
	input  wire logic [swir_pkg::CMD_W-1:0]        s_tuser,  // cmd
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// status_code, status_arg, write_data, write_count, active_now, reboot_request
	output logic      [swir_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic      [swir_pkg::OUT_USER_W-1:0]   m_tuser   // status_valid, write_valid
);
	import swir_pkg::*;

	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [SEQ_W-1:0]  seq_s1;
	logic [DATA_W-1:0] payload_s1;
	logic              advance;
	result_t           result;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	// Move a frame up whenever the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1     <= s_tuser;
			seq_s1     <= s_tdata[SEQ_W-1:0];
			payload_s1 <= s_tdata[IN_DATA_W-1:SEQ_W];
		end
	end

	swir_ctrl #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.cmd     (cmd_s1),
		.seq     (seq_s1),
		.payload (payload_s1),
		.result  (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {result.reboot_request, result.active_now, result.write_count,
				result.write_data, result.status_arg, result.status_code};
			out_user_q <= {result.write_valid, result.status_valid};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

`default_nettype wire

### rtl/core/swir_crc.sv
// Combinational CRC-32 update over 0 to PAYLOAD_BYTES bytes.
// Depends on swir_pkg for the elaboration-time XOR matrices.
`default_nettype none

module swir_crc #(
	parameter int unsigned PAYLOAD_BYTES = swir_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire logic [swir_pkg::CRC_W-1:0]  crc_in,
	input  wire logic [swir_pkg::DATA_W-1:0] data,
	input  wire logic [swir_pkg::CNT_W-1:0]  count,
	output logic      [swir_pkg::CRC_W-1:0]  crc_out
);
	import swir_pkg::*;

	wire [PAYLOAD_BYTES:0][CRC_W-1:0] upd;

	// Zero bytes leave the register as it is
	assign upd[0] = crc_in;

	// One XOR network per byte count
	for (genvar gn = 1; gn <= PAYLOAD_BYTES; gn++) begin : g_len
		localparam crc_smat_t StateMat = crc_state_mat(gn);
		localparam crc_dmat_t DataMat  = crc_data_mat(gn);
		assign upd[gn] = crc_apply(StateMat, DataMat, crc_in, data);
	end

	// Pick the network for this count
	always_comb begin
		crc_out = crc_in;
		for (int n = 1; n <= PAYLOAD_BYTES; n++) begin
			if (count == CNT_W'(n)) crc_out = upd[n];
		end
	end

endmodule

`default_nettype wire

### rtl/core/swir_ctrl.sv
// Frame decode, transfer state and result forming; one frame per cycle on step.
// Depends on swir_pkg and swir_crc.
`default_nettype none

module swir_ctrl #(
	parameter int unsigned PAYLOAD_BYTES = swir_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic [swir_pkg::CMD_W-1:0]   cmd,
	input  wire logic [swir_pkg::SEQ_W-1:0]   seq,
	input  wire logic [swir_pkg::DATA_W-1:0]  payload,
	output swir_pkg::result_t                 result
);
	import swir_pkg::*;

	// Transfer state; the CRC register holds the inverted running CRC
	logic              active_q, active_d;
	logic [LEN_W-1:0]  total_q, total_d;
	logic [LEN_W-1:0]  written_q, written_d;
	logic [SEQ_W-1:0]  expseq_q, expseq_d;
	logic [CRC_W-1:0]  crc_q, crc_d;

	logic [LEN_W:0]    room;
	logic [CNT_W-1:0]  wr_cnt;
	logic [DATA_W-1:0] wr_data;
	logic [CRC_W-1:0]  crc_upd;
	logic [LEN_W-1:0]  rx_word;

	assign rx_word = payload[LEN_W-1:0];

	// Bytes left before the total, clipped to one frame
	always_comb begin
		room = {1'b0, total_q} - {1'b0, written_q};
		if (room[LEN_W] || room[LEN_W-1:0] == '0) begin
			wr_cnt = '0;
		end else if (room[LEN_W-1:0] < LEN_W'(PAYLOAD_BYTES)) begin
			wr_cnt = room[CNT_W-1:0];
		end else begin
			wr_cnt = CNT_W'(PAYLOAD_BYTES);
		end
	end

	// Keep only the bytes that are written
	always_comb begin
		for (int b = 0; b < DATA_W / 8; b++) begin
			wr_data[8*b +: 8] = (CNT_W'(b) < wr_cnt) ? payload[8*b +: 8] : 8'd0;
		end
	end

	swir_crc #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_crc (
		.crc_in  (crc_q),
		.data    (wr_data),
		.count   (wr_cnt),
		.crc_out (crc_upd)
	);

	// Decode the frame and form the answer
	always_comb begin
		result    = '0;
		active_d  = active_q;
		total_d   = total_q;
		written_d = written_q;
		expseq_d  = expseq_q;
		crc_d     = crc_q;
		case (cmd_t'(cmd))
			CMD_BEGIN: begin
				total_d   = rx_word;
				written_d = '0;
				expseq_d  = '0;
				crc_d     = '1;
				active_d  = 1'b1;
				result.status_valid = 1'b1;
				result.status_code  = ST_READY;
			end
			CMD_END: begin
				result.status_valid = 1'b1;
				if (!active_q) begin
					result.status_code = ST_ERR;
					result.status_arg  = ERR_STATE;
				end else if (written_q != total_q) begin
					active_d = 1'b0;
					result.status_code = ST_ERR;
					result.status_arg  = ERR_SIZE;
				end else if (~crc_q != rx_word) begin
					active_d = 1'b0;
					result.status_code = ST_ERR;
					result.status_arg  = ERR_CRC;
				end else begin
					active_d = 1'b0;
					result.status_code    = ST_DONE;
					result.reboot_request = 1'b1;
				end
			end
			CMD_ABORT: begin
				active_d = 1'b0;
			end
			CMD_DATA: begin
				result.status_valid = 1'b1;
				if (!active_q) begin
					result.status_code = ST_ERR;
					result.status_arg  = ERR_STATE;
				end else if (seq == expseq_q) begin
					result.write_valid = (wr_cnt != '0);
					result.write_data  = wr_data;
					result.write_count = wr_cnt;
					crc_d     = crc_upd;
					written_d = written_q + LEN_W'(wr_cnt);
					expseq_d  = expseq_q + 8'd1;
					result.status_code = ST_ACK;
					result.status_arg  = seq;
				end else if (seq == expseq_q - 8'd1) begin
					// duplicate of the last frame: ack again, no write
					result.status_code = ST_ACK;
					result.status_arg  = seq;
				end else begin
					result.status_code = ST_NAK;
					result.status_arg  = expseq_q;
				end
			end
			default: begin
			end
		endcase
		result.active_now = active_d;
	end

	// Advance the transfer state as the frame leaves for the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			total_q   <= '0;
			written_q <= '0;
			expseq_q  <= '0;
			crc_q     <= '1;
		end else if (step) begin
			active_q  <= active_d;
			total_q   <= total_d;
			written_q <= written_d;
			expseq_q  <= expseq_d;
			crc_q     <= crc_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/swir_checker.sv
// Port-level checks on the image receiver's result stream, bound to the top.
// Depends on swir_pkg for field positions and status codes.
`default_nettype none

module swir_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_tready,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [swir_pkg::OUT_DATA_W-1:0]   m_tdata,
	input wire logic [swir_pkg::OUT_USER_W-1:0]   m_tuser
);
	import swir_pkg::*;

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A reboot request comes only with DONE and leaves the transfer idle
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[O_REBOOT_BIT] |-> m_tuser[0] && !m_tdata[O_ACTIVE_BIT]
			&& m_tdata[O_ARG_LSB-1:O_CODE_LSB] == ST_DONE)
		else $error("reboot without a DONE answer");

	// Written bytes come only with an ACK and a nonzero count, in an active transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tdata[O_ACTIVE_BIT]
			&& m_tdata[O_ARG_LSB-1:O_CODE_LSB] == ST_ACK
			&& m_tdata[O_ACTIVE_BIT-1:O_WCOUNT_LSB] != '0)
		else $error("write without an ACK or a count");

	// No write means an empty write field
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata[O_ACTIVE_BIT-1:O_WCOUNT_LSB] == '0
			&& m_tdata[O_WCOUNT_LSB-1:O_WDATA_LSB] == '0)
		else $error("write bytes present without a write");

	// An empty result register never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with an empty result register");

endmodule

bind stop_and_wait_image_receiver_core swir_checker u_swir_checker (.*);

`default_nettype wire

### tb/tb_stop_and_wait_image_receiver_core.sv
// Self-checking testbench for stop_and_wait_image_receiver_core: frame stimulus,
// a behavioral receiver with its own CRC-32, and a field-by-field result check.
// Depends on swir_pkg and the RTL of the receiver core.
`default_nettype none

module tb_stop_and_wait_image_receiver_core;
	import swir_pkg::*;

	localparam int FRAME_BYTES = 7;
	localparam logic [CMD_W-1:0] CMD_OTHER_FIRST = 3'd4;
	localparam logic [CMD_W-1:0] CMD_OTHER_LAST  = 3'd7;
	localparam int IDLE_PCT    = 29;
	localparam int QUIET_FIRST = 500;
	localparam int QUIET_LAST  = 800;
	localparam int FRAME_GOAL  = 1700;

	typedef struct {
		logic [CMD_W-1:0]  kind;
		logic [SEQ_W-1:0]  seq;
		logic [DATA_W-1:0] payload;
	} frame_t;

	// How a generated transfer is closed
	typedef enum {XFER_CLEAN, XFER_SHORT, XFER_BAD_CRC, XFER_ABORT, XFER_RESTART} xfer_end_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;   // seq, payload
	logic [CMD_W-1:0] s_tuser = '0;       // cmd
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;       // code, arg, wdata, wcount, active, reboot
	logic [OUT_USER_W-1:0] m_tuser;       // status_valid, write_valid

	stop_and_wait_image_receiver_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	frame_t  image_frames[$];
	result_t expected_status[$];
	int frames_sent;
	int frames_in;
	int results_out;
	int mismatches;

	// Receiver state as the predictor sees it
	logic             rx_active;
	logic [LEN_W-1:0] rx_total;
	logic [LEN_W-1:0] rx_written;
	logic [SEQ_W-1:0] rx_next_seq;
	logic [CRC_W-1:0] rx_crc;

	initial begin
		forever #5 clk = ~clk;
	end

	// Chainable zlib CRC-32 over the first count bytes, first byte lowest
	function automatic logic [CRC_W-1:0] crc32_fold(logic [CRC_W-1:0] crc_in,
			logic [DATA_W-1:0] bytes, int count);
		logic [CRC_W-1:0] c;
		c = ~crc_in;
		for (int i = 0; i < count; i++) begin
			c = c ^ {24'd0, bytes[8*i +: 8]};
			for (int k = 0; k < 8; k++) begin
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
		end
		return ~c;
	endfunction

	// Work out the status and storage write of one accepted frame
	task automatic predict_receiver(logic [CMD_W-1:0] kind, logic [SEQ_W-1:0] seq,
			logic [DATA_W-1:0] payload);
		result_t r;
		logic [LEN_W-1:0] room;
		int n;
		r = '0;
		r.status_code = ST_READY;
		case (kind)
			CMD_BEGIN: begin
				rx_total = payload[LEN_W-1:0];
				rx_written = '0;
				rx_next_seq = '0;
				rx_crc = '0;
				rx_active = 1'b1;
				r.status_valid = 1'b1;
			end
			CMD_END: begin
				r.status_valid = 1'b1;
				if (!rx_active) begin
					r.status_code = ST_ERR;
					r.status_arg = ERR_STATE;
				end else if (rx_written != rx_total) begin
					r.status_code = ST_ERR;
					r.status_arg = ERR_SIZE;
				end else if (rx_crc != payload[CRC_W-1:0]) begin
					r.status_code = ST_ERR;
					r.status_arg = ERR_CRC;
				end else begin
					r.status_code = ST_DONE;
					r.reboot_request = 1'b1;
				end
				rx_active = 1'b0;
			end
			CMD_ABORT: rx_active = 1'b0;
			CMD_DATA: begin
				r.status_valid = 1'b1;
				if (!rx_active) begin
					r.status_code = ST_ERR;
					r.status_arg = ERR_STATE;
				end else if (seq == rx_next_seq) begin
					room = (rx_total >= rx_written) ? rx_total - rx_written : '0;
					n = (room < FRAME_BYTES) ? int'(room) : FRAME_BYTES;
					if (n > 0) begin
						r.write_data = payload & ({DATA_W{1'b1}} >> (8 * (FRAME_BYTES - n)));
						r.write_count = CNT_W'(n);
						r.write_valid = 1'b1;
						rx_crc = crc32_fold(rx_crc, r.write_data, n);
						rx_written = rx_written + LEN_W'(n);
					end
					rx_next_seq = rx_next_seq + 8'd1;
					r.status_code = ST_ACK;
					r.status_arg = seq;
				end else if (seq == rx_next_seq - 8'd1) begin
					r.status_code = ST_ACK;
					r.status_arg = seq;
				end else begin
					r.status_code = ST_NAK;
					r.status_arg = rx_next_seq;
				end
			end
			default: ;
		endcase
		r.active_now = rx_active;
		expected_status.push_back(r);
	endtask

	function automatic logic [DATA_W-1:0] random_payload();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[DATA_W-1:0];
	endfunction

	// Queue one frame; ignored frame kinds do not count toward the goal
	task automatic push_frame(logic [CMD_W-1:0] kind, logic [SEQ_W-1:0] seq,
			logic [DATA_W-1:0] payload);
		frame_t f;
		f.kind = kind;
		f.seq = seq;
		f.payload = payload;
		image_frames.push_back(f);
		if (kind < CMD_OTHER_FIRST) frames_sent++;
	endtask

	function automatic logic [DATA_W-1:0] len_word(logic [31:0] low32);
		logic [31:0] hi;
		hi = $urandom;
		return {hi[23:0], low32};
	endfunction

	function automatic logic [CMD_W-1:0] CMD_SEL_OTHER();
		return CMD_W'($urandom_range(CMD_OTHER_FIRST, CMD_OTHER_LAST));
	endfunction

	// One transfer: BEGIN, in-order data with duplicates, gaps and junk, then a close if not a restart
	task automatic gen_transfer(logic [LEN_W-1:0] len, xfer_end_t close);
		logic [LEN_W-1:0] written;
		logic [LEN_W-1:0] room;
		logic [CRC_W-1:0] crc;
		logic [SEQ_W-1:0] sq;
		logic [DATA_W-1:0] pl;
		int frames, done_frames, pick, n;
		push_frame(CMD_BEGIN, SEQ_W'($urandom), len_word(len));
		written = '0;
		crc = '0;
		sq = '0;
		if (len > 4000) frames = $urandom_range(0, 8);
		else frames = int'((len + 6) / 7) + (($urandom_range(0, 4) == 0) ? 1 : 0);
		if (close == XFER_SHORT) frames = frames / 2;
		if (close == XFER_ABORT || close == XFER_RESTART) frames = $urandom_range(0, frames);
		done_frames = 0;
		while (done_frames < frames) begin
			pick = $urandom_range(0, 99);
			if (pick < 7) begin
				push_frame(CMD_DATA, sq - 8'd1, random_payload());
			end else if (pick < 12) begin
				push_frame(CMD_DATA, sq + SEQ_W'($urandom_range(1, 254)), random_payload());
			end else if (pick < 14) begin
				push_frame(CMD_SEL_OTHER(), SEQ_W'($urandom), random_payload());
			end else begin
				pl = random_payload();
				room = len - written;
				n = (room < FRAME_BYTES) ? int'(room) : FRAME_BYTES;
				crc = crc32_fold(crc, pl, n);
				written = written + LEN_W'(n);
				push_frame(CMD_DATA, sq, pl);
				sq = sq + 8'd1;
				done_frames++;
			end
		end
		case (close)
			XFER_CLEAN, XFER_SHORT: push_frame(CMD_END, SEQ_W'($urandom), len_word(crc));
			XFER_BAD_CRC: push_frame(CMD_END, SEQ_W'($urandom),
					len_word(crc ^ $urandom_range(1, 32'hFFFF_FFFF)));
			XFER_ABORT: begin
				push_frame(CMD_ABORT, SEQ_W'($urandom), random_payload());
				if ($urandom_range(0, 1) == 1)
					push_frame(CMD_END, SEQ_W'($urandom), len_word(crc));
			end
			default: ;
		endcase
	endtask

	task automatic gen_directed();
		logic [CRC_W-1:0] crc;
		logic [DATA_W-1:0] pl;
		// commands while idle, abort while idle, junk frame
		push_frame(CMD_END, 8'hFF, {DATA_W{1'b1}});
		push_frame(CMD_DATA, 8'h00, '0);
		push_frame(CMD_ABORT, 8'h00, '0);
		push_frame(CMD_OTHER_LAST, 8'hFF, {DATA_W{1'b1}});
		// empty image: the CRC of nothing is zero
		push_frame(CMD_BEGIN, 8'hFF, {24'hFF_FFFF, 32'd0});
		push_frame(CMD_END, 8'h00, {24'hFF_FFFF, 32'd0});
		// short image with duplicates, a gap, clipping and a frame past the end
		push_frame(CMD_BEGIN, 8'h00, {24'd0, 32'd10});
		push_frame(CMD_DATA, 8'hFF, random_payload());
		push_frame(CMD_DATA, 8'h00, {DATA_W{1'b1}});
		push_frame(CMD_DATA, 8'h00, '0);
		push_frame(CMD_DATA, 8'd200, random_payload());
		pl = random_payload();
		push_frame(CMD_DATA, 8'h01, pl);
		push_frame(CMD_DATA, 8'h02, random_payload());
		crc = crc32_fold(crc32_fold('0, {DATA_W{1'b1}}, 7), pl, 3);
		push_frame(CMD_END, 8'h00, len_word(crc));
		// largest length, then a BEGIN that restarts the transfer
		push_frame(CMD_BEGIN, 8'h00, {24'd0, 32'hFFFF_FFFF});
		push_frame(CMD_DATA, 8'h00, random_payload());
		push_frame(CMD_BEGIN, 8'h00, {24'd0, 32'd14});
		push_frame(CMD_DATA, 8'h00, random_payload());
		push_frame(CMD_DATA, 8'h01, random_payload());
		push_frame(CMD_END, 8'h00, len_word(32'hDEAD_BEEF));
		// size mismatch, then END after abort
		push_frame(CMD_BEGIN, 8'h00, {24'd0, 32'd5});
		push_frame(CMD_END, 8'h00, '0);
		push_frame(CMD_BEGIN, 8'h00, {24'd0, 32'd3});
		push_frame(CMD_ABORT, 8'h00, '0);
		push_frame(CMD_END, 8'h00, '0);
	endtask

	task automatic gen_random();
		int pick;
		logic [LEN_W-1:0] len;
		xfer_end_t close;
		// one long image so the sequence number wraps
		gen_transfer(32'd1850, XFER_CLEAN);
		while (frames_sent < FRAME_GOAL) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				case ($urandom_range(0, 3))
					0: push_frame(CMD_DATA, SEQ_W'($urandom), random_payload());
					1: push_frame(CMD_END, SEQ_W'($urandom), random_payload());
					2: push_frame(CMD_ABORT, SEQ_W'($urandom), random_payload());
					default: push_frame(CMD_SEL_OTHER(), SEQ_W'($urandom), random_payload());
				endcase
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 80) len = $urandom_range(0, 60);
				else if (pick < 94) len = $urandom_range(61, 400);
				else len = $urandom;
				pick = $urandom_range(0, 99);
				if (pick < 6) close = XFER_SHORT;
				else if (pick < 12) close = XFER_BAD_CRC;
				else if (pick < 16) close = XFER_ABORT;
				else if (pick < 19) close = XFER_RESTART;
				else close = XFER_CLEAN;
				gen_transfer(len, close);
			end
		end
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Feed frames; predict each one at its transfer
	always @(posedge clk or negedge arst_n) begin
		frame_t f;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_receiver(s_tuser, s_tdata[SEQ_W-1:0], s_tdata[IN_DATA_W-1:SEQ_W]);
				frames_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (image_frames.size() > 0 && ((frames_in >= QUIET_FIRST &&
						frames_in < QUIET_LAST) || $urandom_range(0, 99) >= IDLE_PCT)) begin
					f = image_frames.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {f.payload, f.seq};
					s_tuser <= f.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_status.size() == 0) begin
					$error("result with no frame pending: tdata %0h tuser %0h", m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = expected_status.pop_front();
					check_field("status_valid", 64'(want.status_valid), 64'(m_tuser[0]));
					check_field("write_valid", 64'(want.write_valid), 64'(m_tuser[1]));
					check_field("status_code", 64'(want.status_code),
							64'(m_tdata[O_CODE_LSB +: 3]));
					check_field("status_arg", 64'(want.status_arg),
							64'(m_tdata[O_ARG_LSB +: SEQ_W]));
					check_field("write_data", 64'(want.write_data),
							64'(m_tdata[O_WDATA_LSB +: DATA_W]));
					check_field("write_count", 64'(want.write_count),
							64'(m_tdata[O_WCOUNT_LSB +: CNT_W]));
					check_field("active_now", 64'(want.active_now), 64'(m_tdata[O_ACTIVE_BIT]));
					check_field("reboot_request", 64'(want.reboot_request),
							64'(m_tdata[O_REBOOT_BIT]));
				end
				results_out++;
			end
			m_tready <= (results_out >= QUIET_FIRST && results_out < QUIET_LAST) ||
					($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	initial begin
		frames_sent = 0;
		frames_in = 0;
		results_out = 0;
		mismatches = 0;
		rx_active = 1'b0;
		rx_total = '0;
		rx_written = '0;
		rx_next_seq = '0;
		rx_crc = '0;
		gen_directed();
		gen_random();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// drain stimulus, then all results, then wait out any strays
		while (image_frames.size() != 0 || s_tvalid) @(posedge clk);
		while (expected_status.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Hard stop if the block hangs
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
rtl/core/swir_pkg.sv
rtl/core/swir_crc.sv
rtl/core/swir_ctrl.sv
rtl/core/stop_and_wait_image_receiver_core.sv
rtl/core/swir_checker.sv
tb/tb_stop_and_wait_image_receiver_core.sv
